FILE: hw/rtl/mbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, constants, configuration codes, control types and the
// saturating clamp used by the coordinate mapping and the iteration update.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned FracBits     = 28;
  localparam int unsigned PixelBits    = 12;
  localparam int unsigned StepWidth    = 31;
  localparam int unsigned IterWidth    = 16;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned ProdWidth    = StepWidth + PixelBits;
  localparam int unsigned MapWidth     = ProdWidth + 2;
  localparam int unsigned OpWidth      = FracBits + 2;
  localparam int unsigned SqWidth      = 2 * OpWidth;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic signed [MapWidth-1:0]   wide_t;

  typedef enum logic [1:0] {
    CfgPixelStep  = 2'd0,
    CfgOriginReal = 2'd1,
    CfgOriginImag = 2'd2,
    CfgMaxIter    = 2'd3
  } cfg_idx_e;

  localparam logic [StepWidth-1:0] PixelStepReset  = StepWidth'(559241);
  localparam value_t               OriginRealReset = ValueWidth'(-671088640);
  localparam value_t               OriginImagReset = ValueWidth'(-301989888);
  localparam logic [IterWidth-1:0] MaxIterReset    = IterWidth'(100);

  localparam value_t ValueMax = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam value_t ValueMin = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam value_t TwoPos   = value_t'(1) <<< (FracBits + 1);
  localparam value_t TwoNeg   = -TwoPos;
  localparam logic signed [SqWidth:0] FourSq = (SqWidth+1)'(1) <<< (2 * FracBits + 2);

  typedef struct packed {
    logic capture;
    logic map;
    logic init;
    logic mul;
    logic upd;
    logic emit;
  } mbt_cmd_t;

  typedef struct packed {
    logic escape;
  } mbt_status_t;

  function automatic value_t sat_value(input wide_t a);
    wide_t hi;
    wide_t lo;
    hi = {{(MapWidth-ValueWidth){1'b0}}, ValueMax};
    lo = {{(MapWidth-ValueWidth){1'b1}}, ValueMin};
    if (a > hi) begin
      return ValueMax;
    end else if (a < lo) begin
      return ValueMin;
    end
    return a[ValueWidth-1:0];
  endfunction

endpackage

FILE: hw/rtl/mbt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time channel interfaces
// Valid/ready channels for pixel requests and iteration-count results.
// ----------------------------------------------------------------------------
interface mbt_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [mbt_pkg::PixelBits-1:0] pixel_col;
  logic [mbt_pkg::PixelBits-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbt_result_if;
  logic                          valid;
  logic                          ready;
  logic [mbt_pkg::IterWidth-1:0] iter_count;

  modport source (output valid, output iter_count, input ready);
  modport sink   (input valid, input iter_count, output ready);
endinterface

FILE: hw/rtl/mbt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Configuration registers, pixel-to-plane mapping, squaring multipliers,
// escape test, saturating z update, iteration counter and result register.
// ----------------------------------------------------------------------------
module mbt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  mbt_pkg::cfg_idx_e             cfg_index_i,
  input  logic [mbt_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic [mbt_pkg::PixelBits-1:0] pixel_col_i,
  input  logic [mbt_pkg::PixelBits-1:0] pixel_row_i,
  input  mbt_pkg::mbt_cmd_t             cmd_i,
  output mbt_pkg::mbt_status_t          status_o,
  output logic [mbt_pkg::IterWidth-1:0] iter_count_o
);
  import mbt_pkg::*;

  logic [StepWidth-1:0] pixel_step_q;
  value_t               origin_real_q;
  value_t               origin_imag_q;
  logic [IterWidth-1:0] max_iter_q;

  logic [PixelBits-1:0] col_q;
  logic [PixelBits-1:0] row_q;
  logic [ProdWidth-1:0] prod_re_q;
  logic [ProdWidth-1:0] prod_im_q;
  value_t               cx_q;
  value_t               cy_q;
  value_t               x_q;
  value_t               y_q;
  logic [IterWidth-1:0] iter_q;
  logic [IterWidth-1:0] out_q;
  logic                 large_q;
  logic signed [SqWidth-1:0] xx_q;
  logic signed [SqWidth-1:0] yy_q;
  logic signed [SqWidth-1:0] xy_q;

  wide_t                     map_re;
  wide_t                     map_im;
  value_t                    cx_d;
  value_t                    cy_d;
  logic signed [OpWidth-1:0] x_op;
  logic signed [OpWidth-1:0] y_op;
  logic signed [SqWidth-1:0] xx_d;
  logic signed [SqWidth-1:0] yy_d;
  logic signed [SqWidth-1:0] xy_d;
  logic                      large_d;
  logic signed [SqWidth:0]   sum_sq;
  logic signed [SqWidth:0]   diff_sq;
  wide_t                     x_sum;
  wide_t                     y_sum;
  value_t                    x_d;
  value_t                    y_d;
  logic                      escape;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_step_q  <= PixelStepReset;
      origin_real_q <= OriginRealReset;
      origin_imag_q <= OriginImagReset;
      max_iter_q    <= MaxIterReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPixelStep:  pixel_step_q  <= cfg_data_i[StepWidth-1:0];
        CfgOriginReal: origin_real_q <= cfg_data_i[ValueWidth-1:0];
        CfgOriginImag: origin_imag_q <= cfg_data_i[ValueWidth-1:0];
        CfgMaxIter:    max_iter_q    <= cfg_data_i[IterWidth-1:0];
        default: ;
      endcase
    end
  end

  assign map_re = {{(MapWidth-ValueWidth){origin_real_q[ValueWidth-1]}}, origin_real_q}
                + {{(MapWidth-ProdWidth){1'b0}}, prod_re_q};
  assign map_im = {{(MapWidth-ValueWidth){origin_imag_q[ValueWidth-1]}}, origin_imag_q}
                + {{(MapWidth-ProdWidth){1'b0}}, prod_im_q};
  assign cx_d = sat_value(map_re);
  assign cy_d = sat_value(map_im);

  assign x_op    = x_q[OpWidth-1:0];
  assign y_op    = y_q[OpWidth-1:0];
  assign xx_d    = x_op * x_op;
  assign yy_d    = y_op * y_op;
  assign xy_d    = x_op * y_op;
  assign large_d = (x_q >= TwoPos) || (x_q <= TwoNeg) || (y_q >= TwoPos) || (y_q <= TwoNeg);

  assign sum_sq  = {xx_q[SqWidth-1], xx_q} + {yy_q[SqWidth-1], yy_q};
  assign diff_sq = {xx_q[SqWidth-1], xx_q} - {yy_q[SqWidth-1], yy_q};

  assign x_sum = {{(MapWidth-ValueWidth){cx_q[ValueWidth-1]}}, cx_q}
               + {{(MapWidth-(SqWidth+1-FracBits)){diff_sq[SqWidth]}},
                  diff_sq[SqWidth:FracBits]};
  assign y_sum = {{(MapWidth-ValueWidth){cy_q[ValueWidth-1]}}, cy_q}
               + {{(MapWidth-(SqWidth+1-FracBits)){xy_q[SqWidth-1]}},
                  xy_q[SqWidth-1:FracBits-1]};
  assign x_d = sat_value(x_sum);
  assign y_d = sat_value(y_sum);

  assign escape          = large_q || (sum_sq >= FourSq) || (iter_q >= max_iter_q);
  assign status_o.escape = escape;
  assign iter_count_o    = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
    end
    if (cmd_i.map) begin
      prod_re_q <= pixel_step_q * col_q;
      prod_im_q <= pixel_step_q * row_q;
    end
    if (cmd_i.init) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      x_q    <= cx_d;
      y_q    <= cy_d;
      iter_q <= '0;
    end else if (cmd_i.upd && !escape) begin
      x_q    <= x_d;
      y_q    <= y_d;
      iter_q <= iter_q + IterWidth'(1);
    end
    if (cmd_i.mul) begin
      large_q <= large_d;
      xx_q    <= xx_d;
      yy_q    <= yy_d;
      xy_q    <= xy_d;
    end
    if (cmd_i.emit) begin
      out_q <= iter_q;
    end
  end

endmodule

FILE: hw/rtl/mbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences capture, mapping, multiply and update steps for one pixel and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module mbt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mbt_pkg::mbt_status_t status_i,
  output mbt_pkg::mbt_cmd_t    cmd_o
);
  import mbt_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StMap,
    StInit,
    StMul,
    StUpd,
    StDone
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   space;

  assign space      = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == StIdle) && in_valid_i;
    cmd_o.map     = (state_q == StMap);
    cmd_o.init    = (state_q == StInit);
    cmd_o.mul     = (state_q == StMul);
    cmd_o.upd     = (state_q == StUpd);
    cmd_o.emit    = (((state_q == StUpd) && status_i.escape) || (state_q == StDone)) && space;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StMap;
        end
        StMap:  state_q <= StInit;
        StInit: state_q <= StMul;
        StMul:  state_q <= StUpd;
        StUpd: begin
          if (status_i.escape) begin
            state_q <= space ? StIdle : StDone;
          end else begin
            state_q <= StMul;
          end
        end
        StDone: begin
          if (space) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: hw/rtl/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Pixels are taken one at a time: the next is accepted only once the last has
// left for the result register; each iteration passes through a multiply step
// and an escape-test/update step, reusing the same squaring multipliers.
// The result register lets the next pixel enter while a result waits.
// Reset: asynchronous, active low; restores the default configuration.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  mbt_pkg::cfg_idx_e                cfg_index_i,
  input  logic [mbt_pkg::CfgDataWidth-1:0] cfg_data_i,
  mbt_pixel_if.sink                        pix_i,
  mbt_result_if.source                     res_o
);
  import mbt_pkg::*;

  mbt_cmd_t    cmd;
  mbt_status_t status;

  mbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_col_i  (pix_i.pixel_col),
    .pixel_row_i  (pix_i.pixel_row),
    .cmd_i        (cmd),
    .status_o     (status),
    .iter_count_o (res_o.iter_count)
  );

endmodule
